// File: sv/isqg_pkg.sv
// ---------------------------------------------------------------------------
// isqg_pkg: shared types and constants for the quote generator
// Register indexes, action and side codes, and the structs passed between
// the front-end and the emitter.
// ---------------------------------------------------------------------------
package isqg_pkg;

	localparam int PRICE_IN_W  = 32;
	localparam int INV_W       = 32;
	localparam int ID_W        = 32;
	localparam int PRICE_OUT_W = 48;
	localparam int QTY_W       = 16;
	localparam int MAXINV_W    = 20;
	localparam int SKEW_W      = 16;
	localparam int OFFSET_W    = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 20;
	// clamped inventory fits in a signed word one bit wider than the bound
	localparam int CLAMP_W     = MAXINV_W + 1;
	localparam int PROD_W      = CLAMP_W + SKEW_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INV = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKEW    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QTY     = 8'd3;

	// reset values of the registers
	localparam logic [MAXINV_W-1:0] MAX_INV_RST = 20'd100;
	localparam logic [SKEW_W-1:0]   SKEW_RST    = 16'd1;
	localparam logic [OFFSET_W-1:0] OFFSET_RST  = 16'd1;
	localparam logic [QTY_W-1:0]    QTY_RST     = 16'd1;

	// result codes
	localparam logic ACT_CANCEL = 1'b0;
	localparam logic ACT_SUBMIT = 1'b1;
	localparam logic SIDE_BUY   = 1'b0;
	localparam logic SIDE_SELL  = 1'b1;

	typedef struct packed {
		logic [MAXINV_W-1:0] max_inv;
		logic [SKEW_W-1:0]   skew;
		logic [OFFSET_W-1:0] offset;
		logic [QTY_W-1:0]    qty;
	} cfg_t;

	// which results one observation causes, with the ids involved
	typedef struct packed {
		logic            cancel_bid;
		logic            cancel_ask;
		logic            submit;
		logic [ID_W-1:0] bid_cancel_id;
		logic [ID_W-1:0] ask_cancel_id;
		logic [ID_W-1:0] new_id;
	} plan_t;

	typedef struct packed {
		logic [PRICE_IN_W-1:0]    centre;
		logic signed [CLAMP_W-1:0] inv;
		plan_t                    plan;
	} item_t;

endpackage

// File: sv/isqg_plan.sv
// ---------------------------------------------------------------------------
// isqg_plan: input stage and order bookkeeping
// Picks the centre, clamps inventory, decides cancels and submits, updates
// the id counter and recorded ids at accept, and holds the word in stage 1.
// ---------------------------------------------------------------------------
module isqg_plan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  isqg_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mid_valid,
	input  logic [isqg_pkg::PRICE_IN_W-1:0] mid_price,
	input  logic                          ref_valid,
	input  logic [isqg_pkg::PRICE_IN_W-1:0] ref_price,
	input  logic signed [isqg_pkg::INV_W-1:0] inventory,
	output logic                          valid_s1,
	output isqg_pkg::item_t               item_s1,
	input  logic                          ready_s1
);
	import isqg_pkg::*;

	logic                    accept;
	logic                    has_centre;
	logic                    do_submit;
	logic signed [INV_W-1:0] bound_pos;
	logic signed [INV_W-1:0] bound_neg;
	logic signed [INV_W-1:0] inv_clamped;
	logic [ID_W-1:0]         next_id_q;
	logic                    bid_rec_q;
	logic [ID_W-1:0]         bid_id_q;
	logic                    ask_rec_q;
	logic [ID_W-1:0]         ask_id_q;
	item_t                   item_d;

	assign in_ready   = !valid_s1 || ready_s1;
	assign accept     = in_valid && in_ready;
	assign has_centre = mid_valid || ref_valid;
	// quotes cross only when the offset is zero
	assign do_submit  = (cfg.offset != '0);

	// inventory clamp to +/- bound
	assign bound_pos = $signed({{(INV_W-MAXINV_W){1'b0}}, cfg.max_inv});
	assign bound_neg = -bound_pos;
	always_comb begin
		if (inventory > bound_pos) begin
			inv_clamped = bound_pos;
		end else if (inventory < bound_neg) begin
			inv_clamped = bound_neg;
		end else begin
			inv_clamped = inventory;
		end
	end

	always_comb begin
		item_d.centre             = mid_valid ? mid_price : ref_price;
		item_d.inv                = inv_clamped[CLAMP_W-1:0];
		item_d.plan.cancel_bid    = bid_rec_q;
		item_d.plan.cancel_ask    = ask_rec_q;
		item_d.plan.submit        = do_submit;
		item_d.plan.bid_cancel_id = bid_id_q;
		item_d.plan.ask_cancel_id = ask_id_q;
		item_d.plan.new_id        = next_id_q;
	end

	// order state: new ids are taken at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
			bid_rec_q <= 1'b0;
			bid_id_q  <= '0;
			ask_rec_q <= 1'b0;
			ask_id_q  <= '0;
		end else if (accept && has_centre && do_submit) begin
			next_id_q <= next_id_q + ID_W'(2);
			bid_rec_q <= 1'b1;
			bid_id_q  <= next_id_q;
			ask_rec_q <= 1'b1;
			ask_id_q  <= next_id_q + ID_W'(1);
		end
	end

	// stage 1 register; words without a centre are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && has_centre;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: sv/isqg_emit.sv
// ---------------------------------------------------------------------------
// isqg_emit: pricing and result sequencer
// Forms the reservation price into stage 2 and sends the pending cancels and
// submits one word a cycle through the output register while out_ready allows.
// ---------------------------------------------------------------------------
module isqg_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  isqg_pkg::cfg_t                cfg,
	input  logic                          valid_s1,
	input  isqg_pkg::item_t               item_s1,
	output logic                          ready_s1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          action_kind,
	output logic [isqg_pkg::ID_W-1:0]     order_id,
	output logic                          side,
	output logic signed [isqg_pkg::PRICE_OUT_W-1:0] price,
	output logic [isqg_pkg::QTY_W-1:0]    quantity,
	output logic                          last
);
	import isqg_pkg::*;

	// pending slots: 0 cancel bid, 1 cancel ask, 2 submit buy, 3 submit sell
	logic [3:0]                    pend_s2;
	logic [ID_W-1:0]               bid_cid_s2;
	logic [ID_W-1:0]               ask_cid_s2;
	logic [ID_W-1:0]               new_id_s2;
	logic signed [PRICE_OUT_W-1:0] resv_s2;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PRICE_OUT_W-1:0] resv_d;
	logic signed [PRICE_OUT_W-1:0] offs;
	logic [3:0]                    pick;
	logic [3:0]                    remain;
	logic                          out_load;
	logic                          out_valid_q;
	logic                          kind_d;
	logic [ID_W-1:0]               id_d;
	logic                          side_d;
	logic signed [PRICE_OUT_W-1:0] price_d;
	logic [QTY_W-1:0]              qty_d;

	// reservation = centre - clamped inventory * skew
	assign prod   = item_s1.inv * $signed({1'b0, cfg.skew});
	assign resv_d = $signed({{(PRICE_OUT_W-PRICE_IN_W){1'b0}}, item_s1.centre})
		- {{(PRICE_OUT_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign offs   = $signed({{(PRICE_OUT_W-OFFSET_W){1'b0}}, cfg.offset});

	// lowest pending slot goes first
	assign pick     = pend_s2 & (~pend_s2 + 4'd1);
	assign remain   = pend_s2 & ~pick;
	assign out_load = (pend_s2 != '0) && (!out_valid_q || out_ready);
	assign ready_s1 = (pend_s2 == '0) || (out_load && (remain == '0));

	always_comb begin
		kind_d  = ACT_CANCEL;
		id_d    = bid_cid_s2;
		side_d  = SIDE_BUY;
		price_d = '0;
		qty_d   = '0;
		case (pick)
			4'b0001: begin
				id_d = bid_cid_s2;
			end
			4'b0010: begin
				id_d = ask_cid_s2;
			end
			4'b0100: begin
				kind_d  = ACT_SUBMIT;
				id_d    = new_id_s2;
				price_d = resv_s2 - offs;
				qty_d   = cfg.qty;
			end
			4'b1000: begin
				kind_d  = ACT_SUBMIT;
				id_d    = new_id_s2 + ID_W'(1);
				side_d  = SIDE_SELL;
				price_d = resv_s2 + offs;
				qty_d   = cfg.qty;
			end
			default: begin
				id_d = bid_cid_s2;
			end
		endcase
	end

	// stage 2 pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (ready_s1) begin
			pend_s2 <= valid_s1 ? {item_s1.plan.submit, item_s1.plan.submit,
				item_s1.plan.cancel_ask, item_s1.plan.cancel_bid} : 4'b0000;
		end else if (out_load) begin
			pend_s2 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			bid_cid_s2 <= item_s1.plan.bid_cancel_id;
			ask_cid_s2 <= item_s1.plan.ask_cancel_id;
			new_id_s2  <= item_s1.plan.new_id;
			resv_s2    <= resv_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			action_kind <= kind_d;
			order_id    <= id_d;
			side        <= side_d;
			price       <= price_d;
			quantity    <= qty_d;
			last        <= (remain == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sv/inventory_skewed_quote_generator_core.sv
// The first result word passes the stage 1 register, the stage 2 pending mask and
// the output register after its market word is accepted. One result word per cycle
// while out_ready holds; a market word with a centre causes from 0 to 4 results;
// a word with no centre is dropped in stage 1 and never reaches the sequencer.
// Input is taken every cycle while the sequencer keeps up. Reset (arst_n low)
// clears ids, recorded orders, pipeline valids and restores register defaults.
// ---------------------------------------------------------------------------
// inventory_skewed_quote_generator_core: inventory-skewed quote generator
// Config registers, order bookkeeping front-end and result sequencer.
// ---------------------------------------------------------------------------
module inventory_skewed_quote_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [isqg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isqg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mid_valid,
	input  logic [isqg_pkg::PRICE_IN_W-1:0] mid_price,
	input  logic                          ref_valid,
	input  logic [isqg_pkg::PRICE_IN_W-1:0] ref_price,
	input  logic signed [isqg_pkg::INV_W-1:0] inventory,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          action_kind,
	output logic [isqg_pkg::ID_W-1:0]     order_id,
	output logic                          side,
	output logic signed [isqg_pkg::PRICE_OUT_W-1:0] price,
	output logic [isqg_pkg::QTY_W-1:0]    quantity,
	output logic                          last
);
	import isqg_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	item_t item_s1;
	logic  ready_s1;

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_inv <= MAX_INV_RST;
			cfg_q.skew    <= SKEW_RST;
			cfg_q.offset  <= OFFSET_RST;
			cfg_q.qty     <= QTY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_INV: cfg_q.max_inv <= cfg_data[MAXINV_W-1:0];
				REG_SKEW:    cfg_q.skew    <= cfg_data[SKEW_W-1:0];
				REG_OFFSET:  cfg_q.offset  <= cfg_data[OFFSET_W-1:0];
				REG_QTY:     cfg_q.qty     <= cfg_data[QTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	isqg_plan u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mid_valid (mid_valid),
		.mid_price (mid_price),
		.ref_valid (ref_valid),
		.ref_price (ref_price),
		.inventory (inventory),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.ready_s1  (ready_s1)
	);

	isqg_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.ready_s1    (ready_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action_kind (action_kind),
		.order_id    (order_id),
		.side        (side),
		.price       (price),
		.quantity    (quantity),
		.last        (last)
	);

endmodule

// File: sv/isqg_checker.sv
// ---------------------------------------------------------------------------
// isqg_checker: port-level checks for the quote generator
// Watches the result channel for word ordering and field rules.
// ---------------------------------------------------------------------------
module isqg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          action_kind,
	input logic [isqg_pkg::ID_W-1:0]     order_id,
	input logic                          side,
	input logic signed [isqg_pkg::PRICE_OUT_W-1:0] price,
	input logic [isqg_pkg::QTY_W-1:0]    quantity,
	input logic                          last
);
	import isqg_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(order_id) && $stable(price)
			&& $stable(last))
		else $error("result word changed while stalled");

	// cancels carry zero side, price and quantity
	a_cancel_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action_kind == ACT_CANCEL) |-> (side == SIDE_BUY) && (price == '0)
			&& (quantity == '0))
		else $error("cancel with nonzero fields");

	// buy submit is never the final word; sell submit always is
	a_buy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action_kind == ACT_SUBMIT) && (side == SIDE_BUY) |-> !last)
		else $error("buy submit marked last");

	a_sell_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action_kind == ACT_SUBMIT) && (side == SIDE_SELL) |-> last)
		else $error("sell submit not marked last");

	// the sell follows its buy directly, one id higher and priced above it
	a_sell_after_buy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (action_kind == ACT_SUBMIT) && (side == SIDE_BUY)
			##1 out_valid |-> (action_kind == ACT_SUBMIT) && (side == SIDE_SELL)
			&& (order_id == $past(order_id) + ID_W'(1)) && (price > $past(price)))
		else $error("sell submit does not pair with buy submit");

endmodule

bind inventory_skewed_quote_generator_core isqg_checker u_isqg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.action_kind (action_kind),
	.order_id    (order_id),
	.side        (side),
	.price       (price),
	.quantity    (quantity),
	.last        (last)
);

// File: sim/inventory_skewed_quote_generator_core_test.sv
// ---------------------------------------------------------------------------
// inventory_skewed_quote_generator_core_test: self-checking bench
// Streams market words into the quote generator with random gaps on both
// channels. For each market word it computes the cancel and submit words the
// core should emit, then checks each output word in order against them.
// Register settings change between phases, only while the core is idle.
// ---------------------------------------------------------------------------
module inventory_skewed_quote_generator_core_test;
	import isqg_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 150;
	localparam int PHASE_WORDS  = 60;
	localparam int NUM_PHASES   = 6;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

	typedef struct packed {
		logic                     mid_valid;
		logic [PRICE_IN_W-1:0]    mid_price;
		logic                     ref_valid;
		logic [PRICE_IN_W-1:0]    ref_price;
		logic signed [INV_W-1:0]  inventory;
	} mkt_word_t;

	typedef struct packed {
		logic                          action_kind;
		logic [ID_W-1:0]               order_id;
		logic                          side;
		logic signed [PRICE_OUT_W-1:0] price;
		logic [QTY_W-1:0]              quantity;
		logic                          last;
	} quote_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    mid_valid = 1'b0;
	logic [PRICE_IN_W-1:0]   mid_price = '0;
	logic                    ref_valid = 1'b0;
	logic [PRICE_IN_W-1:0]   ref_price = '0;
	logic signed [INV_W-1:0] inventory = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                          action_kind;
	logic [ID_W-1:0]               order_id;
	logic                          side;
	logic signed [PRICE_OUT_W-1:0] price;
	logic [QTY_W-1:0]              quantity;
	logic                          last;

	// stimulus and expectation stores
	mkt_word_t   mkt_pending[$];
	mkt_word_t   mkt_cur;
	quote_word_t quote_expect[$];

	// shadow of the registers and the order book
	cfg_t            quote_cfg = '{MAX_INV_RST, SKEW_RST, OFFSET_RST, QTY_RST};
	logic [ID_W-1:0] next_id = '0;
	logic            bid_open = 1'b0;
	logic [ID_W-1:0] bid_id = '0;
	logic            ask_open = 1'b0;
	logic [ID_W-1:0] ask_id = '0;

	int   idle_pct = 15;
	int   in_gap = 0;
	int   out_gap = 0;
	int   mkt_taken = 0;
	int   err_cnt = 0;
	logic hold_out = 1'b0;
	int   phase_idle[NUM_PHASES] = '{25, 0, 40, 10, 60, 0};

	inventory_skewed_quote_generator_core dut (.*);

	always #5 clk = ~clk;

	// expected words for one accepted market word; updates the shadow book
	function automatic void predict_quotes(input mkt_word_t m);
		quote_word_t        words[4];
		int                 n;
		logic signed [63:0] centre, inv, bound, skew64, off64, resv, bid_px, ask_px;
		n = 0;
		if (m.mid_valid) centre = {32'd0, m.mid_price};
		else if (m.ref_valid) centre = {32'd0, m.ref_price};
		else return;
		if (bid_open) begin
			words[n] = '{ACT_CANCEL, bid_id, SIDE_BUY, '0, '0, 1'b0};
			n++;
		end
		if (ask_open) begin
			words[n] = '{ACT_CANCEL, ask_id, SIDE_BUY, '0, '0, 1'b0};
			n++;
		end
		inv    = m.inventory;
		bound  = {44'd0, quote_cfg.max_inv};
		skew64 = {48'd0, quote_cfg.skew};
		off64  = {48'd0, quote_cfg.offset};
		if (inv > bound) inv = bound;
		if (inv < -bound) inv = -bound;
		resv   = centre - inv * skew64;
		bid_px = resv - off64;
		ask_px = resv + off64;
		// a zero offset leaves a crossed quote: cancels only, book kept
		if (bid_px < ask_px) begin
			bid_open = 1'b1;
			bid_id   = next_id;
			ask_open = 1'b1;
			ask_id   = next_id + 1;
			next_id  = next_id + 2;
			words[n] = '{ACT_SUBMIT, bid_id, SIDE_BUY, bid_px[PRICE_OUT_W-1:0],
				quote_cfg.qty, 1'b0};
			n++;
			words[n] = '{ACT_SUBMIT, ask_id, SIDE_SELL, ask_px[PRICE_OUT_W-1:0],
				quote_cfg.qty, 1'b0};
			n++;
		end
		if (n > 0) words[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) quote_expect = {quote_expect, words[i]};
	endfunction

	function automatic void cmp_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic void check_quote(input quote_word_t got);
		quote_word_t want;
		if (quote_expect.size() == 0) begin
			$error("unexpected output word, order_id %0d", got.order_id);
			err_cnt++;
			return;
		end
		want = quote_expect.pop_front();
		cmp_field("action_kind", want.action_kind, got.action_kind);
		cmp_field("order_id", want.order_id, got.order_id);
		cmp_field("side", want.side, got.side);
		cmp_field("price", want.price, got.price);
		cmp_field("quantity", want.quantity, got.quantity);
		cmp_field("last", want.last, got.last);
	endfunction

	// market word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_quotes(mkt_cur);
				mkt_taken <= mkt_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (mkt_pending.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
					in_gap = $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else if (mkt_pending.size() > 0) begin
					mkt_cur = mkt_pending.pop_front();
					in_valid  <= 1'b1;
					mid_valid <= mkt_cur.mid_valid;
					mid_price <= mkt_cur.mid_price;
					ref_valid <= mkt_cur.ref_valid;
					ref_price <= mkt_cur.ref_price;
					inventory <= mkt_cur.inventory;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_quote('{action_kind, order_id, side, price, quantity, last});
			if (hold_out) begin
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_gap = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one long receiver stall so the core backs up into its input
	initial begin
		do @(posedge clk); while (mkt_taken < HOLD_AFTER);
		hold_out <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_out <= 1'b0;
	end

	// cfg_valid stays high across back-to-back writes; callers lower it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_MAX_INV: quote_cfg.max_inv = data[MAXINV_W-1:0];
			REG_SKEW:    quote_cfg.skew    = data[SKEW_W-1:0];
			REG_OFFSET:  quote_cfg.offset  = data[OFFSET_W-1:0];
			REG_QTY:     quote_cfg.qty     = data[QTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] max_inv, skew, off, qty);
		write_reg(REG_MAX_INV, max_inv);
		write_reg(REG_SKEW, skew);
		write_reg(REG_OFFSET, off);
		write_reg(REG_QTY, qty);
		cfg_valid <= 1'b0;
	endtask

	// wait out the queued words, the results, and any word with no result
	task automatic wait_idle();
		do @(posedge clk);
		while (mkt_pending.size() != 0 || in_valid || quote_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_mkt(input logic mv, input logic [PRICE_IN_W-1:0] mp,
		input logic rv, input logic [PRICE_IN_W-1:0] rp, input logic signed [INV_W-1:0] inv);
		mkt_word_t w;
		w = '{mv, mp, rv, rp, inv};
		mkt_pending = {mkt_pending, w};
	endfunction

	function automatic logic [PRICE_IN_W-1:0] rand_price();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic mkt_word_t rand_mkt();
		mkt_word_t m;
		int        pick;
		int        k;
		m.mid_price = rand_price();
		m.ref_price = rand_price();
		// mostly mid only; some ref only, both, or neither
		pick = $urandom_range(0, 9);
		m.mid_valid = (pick >= 3);
		m.ref_valid = (pick >= 1 && pick <= 4);
		case ($urandom_range(0, 7))
			0, 1: m.inventory = $urandom;
			2: m.inventory = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			3, 4: begin
				// straddle the clamp bound
				k = int'({12'd0, quote_cfg.max_inv}) + int'($urandom_range(0, 4)) - 2;
				m.inventory = $urandom_range(0, 1) ? k : -k;
			end
			default: m.inventory = int'($urandom_range(0, 600)) - 300;
		endcase
		return m;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_reg(input logic [CFG_DATA_W-1:0] hi);
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = hi;
			2, 3: v = CFG_DATA_W'($urandom_range(0, 1000));
			default: v = CFG_DATA_W'($urandom_range(0, hi));
		endcase
		// junk above a 16-bit register must be dropped by the core
		if (hi != '1) v[CFG_DATA_W-1:QTY_W] = (CFG_DATA_W-QTY_W)'($urandom_range(0, 15));
		return v;
	endfunction

	initial begin : stimulus
		mkt_word_t m;
		int        live;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: bound 100, skew 1, offset 1, quantity 1
		queue_mkt(1'b0, '0, 1'b0, '0, '0);
		queue_mkt(1'b0, '1, 1'b0, '1, 32'sh7FFFFFFF);
		queue_mkt(1'b1, 32'd1000, 1'b0, '0, 32'sd0);
		queue_mkt(1'b0, '1, 1'b1, 32'd5000, 32'sd50);
		queue_mkt(1'b1, 32'd0, 1'b1, 32'd7, 32'sd0);
		queue_mkt(1'b1, '1, 1'b0, '0, 32'sh80000000);
		queue_mkt(1'b0, '0, 1'b1, '1, 32'sh7FFFFFFF);
		queue_mkt(1'b1, 32'd12345, 1'b1, '1, -32'sd37);
		queue_mkt(1'b1, 32'd1, 1'b0, '0, 32'sd100);
		queue_mkt(1'b1, 32'd2, 1'b0, '0, -32'sd101);
		queue_mkt(1'b0, 32'hA5A5A5A5, 1'b0, 32'h5A5A5A5A, -32'sd1);
		wait_idle();

		// widest bound, skew, offset and quantity
		set_regs(20'hFFFFF, 20'h0FFFF, 20'h0FFFF, 20'h0FFFF);
		queue_mkt(1'b1, 32'd0, 1'b0, '0, 32'sh7FFFFFFF);
		queue_mkt(1'b1, '1, 1'b0, '0, 32'sh80000000);
		queue_mkt(1'b0, '0, 1'b1, 32'h80000000, -32'sd1048575);
		wait_idle();

		// zero offset: cancels only, recorded ids and counter stay put
		set_regs(20'd100, 20'd3, 20'd0, 20'd7);
		queue_mkt(1'b1, 32'd500, 1'b0, '0, 32'sd10);
		queue_mkt(1'b0, '0, 1'b1, 32'd600, -32'sd5);
		queue_mkt(1'b0, '0, 1'b0, '0, 32'sd0);
		wait_idle();

		// no clamp room, no skew, zero quantity; writes to unused indexes
		write_reg(REG_SPARE_LO, 20'hFFFFF);
		write_reg(REG_SPARE_HI, 20'h5A5A5);
		set_regs(20'd0, 20'd0, 20'd2, 20'd0);
		queue_mkt(1'b1, 32'd77, 1'b0, '0, 32'sh7FFFFFFF);
		queue_mkt(1'b1, '1, 1'b1, '0, -32'sd1);
		queue_mkt(1'b0, '1, 1'b1, 32'd0, 32'sd0);
		wait_idle();

		// random phases, each with fresh settings; last one runs without gaps
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct <= phase_idle[p];
			set_regs(rand_reg(20'hFFFFF), rand_reg(20'h0FFFF), rand_reg(20'h0FFFF),
				rand_reg(20'h0FFFF));
			live = 0;
			while (live < PHASE_WORDS) begin
				m = rand_mkt();
				mkt_pending = {mkt_pending, m};
				if (m.mid_valid || m.ref_valid) live++;
			end
			wait_idle();
		end

		if (err_cnt == 0) $display("inventory_skewed_quote_generator_core_test: PASS");
		else $display("inventory_skewed_quote_generator_core_test: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("inventory_skewed_quote_generator_core_test: FAIL");
		$finish;
	end

endmodule

// File: inventory_skewed_quote_generator_core.f
sv/isqg_pkg.sv
sv/isqg_plan.sv
sv/isqg_emit.sv
sv/inventory_skewed_quote_generator_core.sv
sv/isqg_checker.sv
sim/inventory_skewed_quote_generator_core_test.sv
